[sv/btds_pkg.sv]
`timescale 1ns / 1ps

package btds_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int SYM_W         = 8;
    localparam int FUNC_W        = 2;
    localparam int CFG_IDX_W     = 2;

    // Depth of the queue between front and back; a power of two is not required.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PROC  = 2'd0,
        FUNC_LOAD  = 2'd1,
        FUNC_START = 2'd2
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELETE  = 2'd0,
        CFG_SQUEEZE = 2'd1,
        CFG_SECOND  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic delete_mode;
        logic squeeze_mode;
        logic second_set_given;
    } t_cfg;

    // One queue entry: a stream start, or a byte ready for the squeeze check.
    typedef struct packed {
        logic             start;
        logic             elig;
        logic [SYM_W-1:0] sym;
    } t_q_item;

    function automatic logic in_range(input logic [SYM_W-1:0] s);
        in_range = {1'b0, s} < (SYM_W + 1)'(TABLE_ENTRIES);
    endfunction

endpackage

[sv/btds_in_if.sv]
`timescale 1ns / 1ps

interface btds_in_if;
    logic                        valid;
    logic                        ready;
    logic [btds_pkg::FUNC_W-1:0] func;
    logic [btds_pkg::SYM_W-1:0]  symbol;
    logic [btds_pkg::SYM_W-1:0]  map_value;
    logic                        in_first_set;
    logic                        in_second_set;

    modport source (
        output valid, func, symbol, map_value, in_first_set, in_second_set,
        input  ready
    );
    modport sink (
        input  valid, func, symbol, map_value, in_first_set, in_second_set,
        output ready
    );
endinterface

[sv/btds_out_if.sv]
`timescale 1ns / 1ps

interface btds_out_if;
    logic                       valid;
    logic                       ready;
    logic [btds_pkg::SYM_W-1:0] out_symbol;

    modport source (output valid, out_symbol, input ready);
    modport sink (input valid, out_symbol, output ready);
endinterface

[sv/btds_ram.sv]
`timescale 1ns / 1ps

module btds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // A read at the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[sv/btds_front.sv]
`timescale 1ns / 1ps

module btds_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  btds_pkg::t_cfg                i_cfg,
    input  logic [btds_pkg::QCNT_W-1:0]   i_q_cnt,
    btds_in_if.sink                       i_in,
    output logic                          o_push,
    output btds_pkg::t_q_item             o_push_item
);
    import btds_pkg::*;

    logic                 accept;
    logic                 rng0;
    logic                 load_we;
    logic [SYM_W:0]       tbl_rd;
    logic                 m2_rd;
    logic [QCNT_W:0]      used;

    logic                 r_v1;
    logic                 r_start1;
    logic [SYM_W-1:0]     r_sym1;
    logic                 r_rng1;
    logic [SYM_W-1:0]     emit1;
    logic                 mark1;
    logic                 drop1;

    logic                 r_v2;
    logic                 r_start2;
    logic [SYM_W-1:0]     r_sym2;
    logic                 r_mark1_2;
    logic                 r_rng2;
    logic                 mark2;
    logic                 in_sq;

    // Every request in flight holds a queue slot, so the pipeline never has to stall.
    assign used        = (QCNT_W + 1)'(i_q_cnt) + (QCNT_W + 1)'(r_v1) + (QCNT_W + 1)'(r_v2);
    assign i_in.ready  = used < (QCNT_W + 1)'(QDEPTH);
    assign accept      = i_in.valid & i_in.ready;
    assign rng0        = in_range(i_in.symbol);
    assign load_we     = accept & (i_in.func == FUNC_LOAD) & rng0;

    btds_ram #(.WIDTH(SYM_W + 1), .DEPTH(TABLE_ENTRIES)) u_tbl_ram (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (i_in.symbol[IDX_W-1:0]),
        .i_wdata ({i_in.map_value, i_in.in_first_set}),
        .i_raddr (i_in.symbol[IDX_W-1:0]),
        .o_rdata (tbl_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= accept & ((i_in.func == FUNC_PROC) | (i_in.func == FUNC_START));
        end
        r_start1 <= i_in.func == FUNC_START;
        r_sym1   <= i_in.symbol;
        r_rng1   <= rng0;
    end

    // In delete mode the byte passes untranslated, and the second-set mark
    // is looked up at the input byte instead of the translated one.
    always_comb begin
        mark1 = r_rng1 & tbl_rd[0];
        if (i_cfg.delete_mode) begin
            emit1 = r_sym1;
        end else if (r_rng1) begin
            emit1 = tbl_rd[SYM_W:1];
        end else begin
            emit1 = r_sym1;
        end
        drop1 = i_cfg.delete_mode & mark1 & ~r_start1;
    end

    btds_ram #(.WIDTH(1), .DEPTH(TABLE_ENTRIES)) u_m2_ram (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (i_in.symbol[IDX_W-1:0]),
        .i_wdata (i_in.in_second_set),
        .i_raddr (emit1[IDX_W-1:0]),
        .o_rdata (m2_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1 & ~drop1;
        end
        r_start2  <= r_start1;
        r_sym2    <= emit1;
        r_mark1_2 <= mark1;
        r_rng2    <= in_range(emit1);
    end

    always_comb begin
        mark2 = r_rng2 & m2_rd;
        if (i_cfg.second_set_given) begin
            in_sq = mark2;
        end else begin
            in_sq = ~i_cfg.delete_mode & r_mark1_2;
        end
        o_push            = r_v2;
        o_push_item.start = r_start2;
        o_push_item.elig  = i_cfg.squeeze_mode & in_sq;
        o_push_item.sym   = r_sym2;
    end

endmodule

[sv/btds_fifo.sv]
`timescale 1ns / 1ps

module btds_fifo (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  btds_pkg::t_q_item           i_item,
    input  logic                        i_pop,
    output btds_pkg::t_q_item           o_item,
    output logic [btds_pkg::QCNT_W-1:0] o_cnt
);
    import btds_pkg::*;

    t_q_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QCNT_W-1:0]   r_cnt;
    logic [QPTR_W-1:0]   n_wr;
    logic [QPTR_W-1:0]   n_rd;
    logic [QCNT_W-1:0]   n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_item = r_mem[r_rd];
    assign o_cnt  = r_cnt;

endmodule

[sv/btds_back.sv]
`timescale 1ns / 1ps

module btds_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [btds_pkg::QCNT_W-1:0] i_q_cnt,
    input  btds_pkg::t_q_item           i_item,
    output logic                        o_pop,
    btds_out_if.source                  o_out
);
    import btds_pkg::*;

    logic             r_out_valid;
    logic [SYM_W-1:0] r_out_sym;
    logic             r_prev_valid;
    logic [SYM_W-1:0] r_prev_sym;
    logic             n_out_valid;
    logic [SYM_W-1:0] n_out_sym;
    logic             n_prev_valid;
    logic [SYM_W-1:0] n_prev_sym;
    logic             can_take;
    logic             repeat_hit;

    assign can_take   = ~r_out_valid | o_out.ready;
    assign o_pop      = (i_q_cnt != '0) & can_take;
    assign repeat_hit = i_item.elig & r_prev_valid & (i_item.sym == r_prev_sym);

    always_comb begin
        n_out_valid  = r_out_valid & ~o_out.ready;
        n_out_sym    = r_out_sym;
        n_prev_valid = r_prev_valid;
        n_prev_sym   = r_prev_sym;
        if (o_pop) begin
            if (i_item.start) begin
                n_prev_valid = 1'b0;
            end else if (!repeat_hit) begin
                n_out_valid  = 1'b1;
                n_out_sym    = i_item.sym;
                n_prev_valid = 1'b1;
                n_prev_sym   = i_item.sym;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_prev_valid <= 1'b0;
            r_prev_sym   <= '0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_prev_valid <= n_prev_valid;
            r_prev_sym   <= n_prev_sym;
        end
        r_out_sym <= n_out_sym;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_symbol = r_out_sym;

endmodule

[sv/byte_translate_delete_squeeze.sv]
`timescale 1ns / 1ps
// Channel   Port     Direction  Payload
// input     i_in     sink       func, symbol, map_value, in_first_set, in_second_set
// output    o_out    source     out_symbol
// config    i_cfg_*  write      delete_mode, squeeze_mode, second_set_given
//
// Sustains one request per cycle while the output keeps up. A processed byte reaches
// the output register through two dependent table reads (map and first-set
// mark, then second-set mark) and one queue stage ahead of the squeeze check.
// Synchronous active-low reset clears control and configuration; the tables
// are not cleared and must be loaded before use. When the output stalls, the
// four-entry queue fills and input ready drops once queue plus in-flight reach four.

module byte_translate_delete_squeeze (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    btds_in_if.sink                        i_in,
    btds_out_if.source                     o_out,
    input  logic                           i_cfg_we,
    input  logic [btds_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic                           i_cfg_data
);
    import btds_pkg::*;

    t_cfg              r_cfg;
    logic              push;
    t_q_item           push_item;
    logic              pop;
    t_q_item           head_item;
    logic [QCNT_W-1:0] q_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DELETE:  r_cfg.delete_mode      <= i_cfg_data;
                CFG_SQUEEZE: r_cfg.squeeze_mode     <= i_cfg_data;
                CFG_SECOND:  r_cfg.second_set_given <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    btds_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_cnt     (q_cnt),
        .i_in        (i_in),
        .o_push      (push),
        .o_push_item (push_item)
    );

    btds_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_cnt   (q_cnt)
    );

    btds_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q_cnt (q_cnt),
        .i_item  (head_item),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

[test/byte_translate_delete_squeeze_tb.sv]
`timescale 1ns / 1ps

module byte_translate_delete_squeeze_tb;
    import btds_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASES        = 32;
    localparam int PHASE_ITEMS   = 32;

    // Predicts the filtered byte stream and holds the bytes still owed by the block.
    class tr_filter_model;
        logic [SYM_W-1:0] map_tbl [TABLE_ENTRIES];
        bit               first_mark [TABLE_ENTRIES];
        bit               second_mark [TABLE_ENTRIES];
        bit               del_on;
        bit               sq_on;
        bit               second_on;
        logic [SYM_W-1:0] last_byte;
        bit               last_valid;
        logic [SYM_W-1:0] expected_bytes [$];
        int               errors;

        function new();
            del_on     = 0;
            sq_on      = 0;
            second_on  = 0;
            last_byte  = '0;
            last_valid = 0;
            errors     = 0;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void set_reg(t_cfg_idx idx, logic v);
            case (idx)
                CFG_DELETE:  del_on = v;
                CFG_SQUEEZE: sq_on = v;
                CFG_SECOND:  second_on = v;
                default: ;
            endcase
        endfunction

        function void note_request(logic [FUNC_W-1:0] f, logic [SYM_W-1:0] s,
                                   logic [SYM_W-1:0] m, logic a, logic b);
            logic [SYM_W-1:0] emit;
            bit               sq;
            case (f)
                FUNC_LOAD: begin
                    map_tbl[s]     = m;
                    first_mark[s]  = a;
                    second_mark[s] = b;
                end
                FUNC_START: last_valid = 0;
                FUNC_PROC: begin
                    if (del_on) begin
                        if (first_mark[s])
                            return;
                        emit = s;
                        // Without a second set, delete mode never squeezes.
                        sq = second_on && second_mark[s];
                    end else begin
                        emit = map_tbl[s];
                        sq = second_on ? second_mark[emit] : first_mark[s];
                    end
                    if (sq_on && sq && last_valid && emit == last_byte)
                        return;
                    last_byte  = emit;
                    last_valid = 1;
                    expected_bytes.push_back(emit);
                end
                default: ;
            endcase
        endfunction

        task check_byte(logic [SYM_W-1:0] got);
            logic [SYM_W-1:0] want;
            if (expected_bytes.size() == 0) begin
                report($sformatf("output 0x%02h while no byte was expected", got));
            end else begin
                want = expected_bytes.pop_front();
                if (got !== want)
                    report($sformatf("out_symbol 0x%02h, expected 0x%02h", got, want));
            end
        endtask

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic i_cfg_data;

    btds_in_if  in_ch ();
    btds_out_if out_ch ();

    byte_translate_delete_squeeze i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    tr_filter_model model = new();

    int idle_pct   = 0;
    int stall_pct  = 0;
    int hold_asks  = 0;
    int hold_taken = 0;
    int hold_left  = 0;
    logic [SYM_W-1:0] last_sym = '0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off whenever the main flow asks for one.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_taken != hold_asks) begin
                hold_taken = hold_asks;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // The output is checked before the request of the same edge is noted; a request
    // can never produce its byte at the edge that accepts it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready)
                model.check_byte(out_ch.out_symbol);
            if (in_ch.valid && in_ch.ready)
                model.note_request(in_ch.func, in_ch.symbol, in_ch.map_value,
                                   in_ch.in_first_set, in_ch.in_second_set);
        end
    end

    task send_request(logic [FUNC_W-1:0] f, logic [SYM_W-1:0] s, logic [SYM_W-1:0] m,
                      logic a, logic b);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.func          <= f;
        in_ch.symbol        <= s;
        in_ch.map_value     <= m;
        in_ch.in_first_set  <= a;
        in_ch.in_second_set <= b;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task process_byte(logic [SYM_W-1:0] s);
        send_request(FUNC_PROC, s, SYM_W'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task wait_idle();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (model.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task set_config(logic del, logic sq, logic sec);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_DELETE;
        i_cfg_data <= del;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SQUEEZE;
        i_cfg_data <= sq;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SECOND;
        i_cfg_data <= sec;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        model.set_reg(CFG_DELETE, del);
        model.set_reg(CFG_SQUEEZE, sq);
        model.set_reg(CFG_SECOND, sec);
    endtask

    initial begin
        int r;
        int q;
        int mode;
        logic [SYM_W-1:0] s;
        logic [SYM_W-1:0] m;

        in_ch.valid         = 1'b0;
        in_ch.func          = FUNC_PROC;
        in_ch.symbol        = '0;
        in_ch.map_value     = '0;
        in_ch.in_first_set  = 1'b0;
        in_ch.in_second_set = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = CFG_DELETE;
        i_cfg_data          = 1'b0;
        i_rst_n             = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every entry is loaded first; many map into a narrow band so that
        // different bytes translate to the same output.
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            m = ($urandom_range(1)) ? SYM_W'($urandom_range(8'h40, 8'h47)) : SYM_W'($urandom);
            send_request(FUNC_LOAD, SYM_W'(i), m, 1'($urandom), 1'($urandom));
        end

        // Plain translation, byte extremes, unused function code.
        send_request(FUNC_LOAD, 8'h00, 8'hFF, 1'b0, 1'b1);
        send_request(FUNC_LOAD, 8'hFF, 8'h00, 1'b1, 1'b0);
        send_request(FUNC_LOAD, 8'h41, 8'h42, 1'b1, 1'b1);
        send_request(FUNC_LOAD, 8'h42, 8'h42, 1'b0, 1'b1);
        process_byte(8'h00);
        process_byte(8'hFF);
        process_byte(8'h41);
        send_request(FUNC_UNUSED, 8'hFF, 8'hFF, 1'b1, 1'b1);
        send_request(FUNC_UNUSED, 8'h00, 8'h00, 1'b0, 1'b0);
        wait_idle();

        // Squeeze on first-set marks of the input; a start forgets the last
        // byte, a load does not.
        set_config(1'b0, 1'b1, 1'b0);
        process_byte(8'h41);
        process_byte(8'h41);
        send_request(FUNC_START, 8'h00, 8'h00, 1'b0, 1'b0);
        process_byte(8'h41);
        send_request(FUNC_LOAD, 8'h10, 8'h10, 1'b0, 1'b0);
        process_byte(8'h41);
        wait_idle();

        // Squeeze on second-set marks of the translated byte.
        set_config(1'b0, 1'b1, 1'b1);
        send_request(FUNC_START, 8'hFF, 8'hFF, 1'b1, 1'b1);
        process_byte(8'h41);
        process_byte(8'h42);
        wait_idle();

        // Delete mode without a second set: drops, but no squeezing.
        set_config(1'b1, 1'b1, 1'b0);
        process_byte(8'h41);
        process_byte(8'h42);
        process_byte(8'h42);
        process_byte(8'hFF);
        wait_idle();

        // Delete mode with a second set squeezes untranslated bytes.
        set_config(1'b1, 1'b1, 1'b1);
        send_request(FUNC_START, 8'h00, 8'h00, 1'b0, 1'b0);
        process_byte(8'h00);
        process_byte(8'h00);
        process_byte(8'h42);
        process_byte(8'h42);
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            mode = p % 4;
            if (mode == 0) begin
                q = p / 4;
                set_config(q[0], q[1], q[2]);
            end
            idle_pct  = (mode == 1) ? 50 : (mode == 3) ? 34 : 0;
            stall_pct = (mode == 2) ? 50 : (mode == 3) ? 34 : 0;
            // Long receiver hold-off while requests keep coming, so the queue fills.
            if (p == 2 || p == 18)
                hold_asks++;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(99);
                if (r < 70) begin
                    q = $urandom_range(99);
                    if (q < 30)
                        s = last_sym;
                    else if (q < 65)
                        s = SYM_W'($urandom_range(8'h40, 8'h47));
                    else if (q < 70)
                        s = ($urandom_range(1)) ? 8'hFF : 8'h00;
                    else
                        s = SYM_W'($urandom);
                    last_sym = s;
                    process_byte(s);
                end else if (r < 82) begin
                    s = ($urandom_range(1)) ? SYM_W'($urandom_range(8'h40, 8'h47))
                                            : SYM_W'($urandom);
                    m = ($urandom_range(1)) ? SYM_W'($urandom_range(8'h40, 8'h47))
                                            : SYM_W'($urandom);
                    send_request(FUNC_LOAD, s, m, 1'($urandom), 1'($urandom));
                end else if (r < 93) begin
                    send_request(FUNC_START, SYM_W'($urandom), SYM_W'($urandom),
                                 1'($urandom), 1'($urandom));
                end else begin
                    send_request(FUNC_UNUSED, SYM_W'($urandom), SYM_W'($urandom),
                                 1'($urandom), 1'($urandom));
                end
            end
            wait_idle();
        end

        if (model.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
